>>> rtl/core/kgr_pkg.sv
// ----------------------------------------------------------------------------
// kgr_pkg
// Shared word types and fixed widths for the k-group reverse stream.
// ----------------------------------------------------------------------------
`default_nettype none

package kgr_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_W   = 5;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      end_of_sequence;
	} src_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic                      out_last;
	} dst_word_t;

endpackage

`default_nettype wire

>>> rtl/core/kgr_ram.sv
// ----------------------------------------------------------------------------
// kgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/k_group_reverse_stream.sv
// ----------------------------------------------------------------------------
// k_group_reverse_stream
// Buffers a stream of signed values and emits each group of group_size
// values reversed; a short tail at the end of a sequence leaves in order.
// ----------------------------------------------------------------------------
// Each input word is written into a group RAM. An input word that
// completes a group, or carries the end mark, starts a drain of all
// buffered values, during which src_stall is high. The drain reads the RAM
// one entry at a time through its one registered read port: every result
// passes a read state, then a load into the output register, which waits
// while dst_stall holds the output register. group_size is written over
// the cfg port, clamped to 1..MAX_GROUP; the user must write it only while
// the block is idle, as the block itself does not enforce this.
`default_nettype none

module k_group_reverse_stream #(
	parameter int MAX_GROUP = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       src_valid,
	output      logic                       src_stall,
	input  wire kgr_pkg::src_word_t         src_word,
	output      logic                       dst_valid,
	input  wire logic                       dst_stall,
	output      kgr_pkg::dst_word_t         dst_word,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [kgr_pkg::CFG_W-1:0]  cfg_data
);

	localparam int AW   = $clog2(MAX_GROUP);
	localparam int GS_W = $clog2(MAX_GROUP + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]                     state_q;
	logic [GS_W-1:0]                group_size_q;
	logic [GS_W-1:0]                fill_q;
	logic [GS_W-1:0]                left_q;
	logic [AW-1:0]                  addr_q;
	logic                           rev_q;
	logic                           eos_q;
	logic                           dst_valid_q;
	kgr_pkg::dst_word_t             dst_word_q;

	logic                           src_acc;
	logic                           dst_acc;
	logic                           load;
	logic [GS_W-1:0]                n;
	logic                           full;
	logic [GS_W-1:0]                gs_new;
	logic [kgr_pkg::VALUE_W-1:0]    rd_data;

	assign src_stall = (state_q != ST_IDLE);
	assign src_acc   = src_valid && !src_stall;
	assign dst_acc   = dst_valid_q && !dst_stall;
	assign load      = (state_q == ST_LOAD) && (!dst_valid_q || !dst_stall);
	assign n         = fill_q + GS_W'(1);
	assign full      = (n >= group_size_q);
	assign cfg_ready = 1'b1;
	assign dst_valid = dst_valid_q;
	assign dst_word  = dst_word_q;

	// clamp to 1..MAX_GROUP
	always_comb begin
		priority if (cfg_data == '0) begin
			gs_new = GS_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_GROUP)) begin
			gs_new = GS_W'(MAX_GROUP);
		end else begin
			gs_new = GS_W'(cfg_data);
		end
	end

	kgr_ram #(
		.WIDTH(kgr_pkg::VALUE_W),
		.DEPTH(MAX_GROUP)
	) u_group_ram (
		.clk  (clk),
		.we   (src_acc),
		.waddr(fill_q[AW-1:0]),
		.wdata(src_word.value),
		.re   (state_q == ST_READ),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			group_size_q <= GS_W'(1);
			fill_q       <= '0;
			left_q       <= '0;
			addr_q       <= '0;
			rev_q        <= 1'b0;
			eos_q        <= 1'b0;
			dst_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				group_size_q <= gs_new;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (src_acc) begin
						if (full || src_word.end_of_sequence) begin
							state_q <= ST_READ;
							left_q  <= n;
							rev_q   <= full;
							eos_q   <= src_word.end_of_sequence;
							addr_q  <= full ? fill_q[AW-1:0] : '0;
							fill_q  <= '0;
						end else begin
							fill_q <= n;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load) begin
						left_q  <= left_q - GS_W'(1);
						addr_q  <= rev_q ? addr_q - AW'(1) : addr_q + AW'(1);
						state_q <= (left_q == GS_W'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				dst_valid_q <= 1'b1;
			end else if (dst_acc) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dst_word_q.out_value <= rd_data;
			dst_word_q.out_last  <= eos_q && (left_q == GS_W'(1));
		end
	end

	a_fill_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < GS_W'(MAX_GROUP))
		else $error("group fill count reached capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (left_q != '0))
		else $error("drain active with nothing left");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_LOAD))
		else $error("read not followed by load");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(group_size_q != '0) && (group_size_q <= GS_W'(MAX_GROUP)))
		else $error("group size out of range");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams signed words with end marks through k_group_reverse_stream under
// a range of group sizes (clamped, zero, lowered mid-group). It predicts the
// reordered output of every accepted word and checks each output word in
// order against that prediction. Random source gaps and output stall bursts.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_GROUP   = 16;
	localparam int TOTAL_ITEMS = 270;
	localparam int CYCLE_LIMIT = 400000;

	class reversal_scoreboard;
		logic [kgr_pkg::VALUE_W-1:0] held_values [MAX_GROUP];
		int unsigned                 held_count;
		int unsigned                 group_len;
		kgr_pkg::dst_word_t          reordered_q [$];
		int unsigned                 errors;

		function new();
			held_count = 0;
			group_len  = 1;
			errors     = 0;
		endfunction

		function void set_group_len(logic [kgr_pkg::CFG_W-1:0] d);
			if (d == 0) begin
				group_len = 1;
			end else if (d > MAX_GROUP) begin
				group_len = MAX_GROUP;
			end else begin
				group_len = 32'(d);
			end
		endfunction

		function void note_source_word(kgr_pkg::src_word_t w);
			kgr_pkg::dst_word_t r;
			int unsigned        n;
			if (held_count < MAX_GROUP) begin
				held_values[held_count] = w.value;
				held_count++;
			end
			n = held_count;
			if (n >= group_len) begin
				// full group leaves reversed
				for (int unsigned i = 0; i < n; i++) begin
					r.out_value = held_values[n - 1 - i];
					r.out_last  = w.end_of_sequence && (i == n - 1);
					reordered_q.push_back(r);
				end
				held_count = 0;
			end else if (w.end_of_sequence) begin
				// short tail leaves in order
				for (int unsigned i = 0; i < n; i++) begin
					r.out_value = held_values[i];
					r.out_last  = (i == n - 1);
					reordered_q.push_back(r);
				end
				held_count = 0;
			end
		endfunction

		function void check_reordered_word(kgr_pkg::dst_word_t got);
			kgr_pkg::dst_word_t want;
			if (reordered_q.size() == 0) begin
				$error("unexpected word: out_value %0d out_last %0b",
					got.out_value, got.out_last);
				errors++;
				return;
			end
			want = reordered_q.pop_front();
			if (got.out_value !== want.out_value) begin
				$error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
				errors++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
				errors++;
			end
		endfunction

		function int pending();
			return reordered_q.size();
		endfunction
	endclass

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      src_valid = 1'b0;
	logic                      src_stall;
	kgr_pkg::src_word_t        src_word  = '0;
	logic                      dst_valid;
	logic                      dst_stall = 1'b0;
	kgr_pkg::dst_word_t        dst_word;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [kgr_pkg::CFG_W-1:0] cfg_data  = '0;

	reversal_scoreboard sb;
	int unsigned        sent       = 0;
	int unsigned        idle_odds  = 0;
	int unsigned        stall_left = 0;
	int unsigned        cycles     = 0;

	k_group_reverse_stream #(
		.MAX_GROUP(MAX_GROUP)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word (src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word (dst_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output side stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
			dst_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			dst_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			sb.check_reordered_word(dst_word);
		end
	end

	function automatic logic [kgr_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [kgr_pkg::VALUE_W-1:0] v, input logic eos);
		kgr_pkg::src_word_t w;
		w.value           = v;
		w.end_of_sequence = eos;
		if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word  <= w;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		sb.note_source_word(w);
		sent++;
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [kgr_pkg::CFG_W-1:0] d);
		wait_drained();
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_group_len(d);
	endtask

	initial begin
		int unsigned               n_seq;
		int unsigned               len;
		int unsigned               g;
		logic                      open_end;
		logic [kgr_pkg::CFG_W-1:0] d;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_odds = 25;
		// pass-through from reset, value extremes
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h8000_0000, 1'b1);
		// oversized write, tail shorter than a group
		write_group_size(5'd31);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0005, 1'b1);
		// zero write gives pass-through
		write_group_size(5'd0);
		send_word(32'h1234_5678, 1'b0);
		// group size lowered while a group is filling
		write_group_size(5'd4);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h0000_0002, 1'b0);
		send_word(32'h0000_0003, 1'b0);
		write_group_size(5'd2);
		send_word(32'h0000_0004, 1'b0);
		// group completes on the end mark
		write_group_size(5'd3);
		send_word(32'hFFFF_FFF0, 1'b0);
		send_word(32'h8000_0001, 1'b0);
		send_word(32'h7FFF_FFFE, 1'b1);
		// odd length with pairs
		write_group_size(5'd2);
		send_word(32'hA5A5_A5A5, 1'b0);
		send_word(32'h5A5A_5A5A, 1'b0);
		send_word(32'hDEAD_BEEF, 1'b1);

		while (sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 9))
				0: d = 5'd16;
				1: d = 5'd31;
				2: d = $urandom_range(0, 1) ? 5'd0 : 5'd1;
				3: d = 5'($urandom_range(17, 30));
				default: d = 5'($urandom_range(2, 8));
			endcase
			write_group_size(d);
			g = sb.group_len;
			case ($urandom_range(0, 2))
				0: idle_odds = 0;
				1: idle_odds = 15;
				default: idle_odds = 35;
			endcase
			n_seq = $urandom_range(1, 4);
			repeat (n_seq) begin
				len      = $urandom_range(1, 2 * g + 1);
				open_end = ($urandom_range(0, 5) == 0);
				for (int unsigned k = 0; k < len && sent < TOTAL_ITEMS; k++) begin
					if (sent + 40 >= TOTAL_ITEMS) begin
						idle_odds = 0;
					end
					send_word(pick_value(), (k == len - 1) && !open_end);
				end
				if ($urandom_range(0, 7) == 0) begin
					wait_drained();
				end
			end
		end

		idle_odds = 0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

>>> files.f
rtl/core/kgr_pkg.sv
rtl/core/kgr_ram.sv
rtl/core/k_group_reverse_stream.sv
dv/tb_top.sv
